[src/mcfe_pkg.sv]
// shared types, constants and functions of the motor command frame encoder
`default_nettype none
package mcfe_pkg;

   localparam int PAYLOAD_BYTES = 15;
   localparam int FRAME_BYTES   = PAYLOAD_BYTES + 2;
   localparam int INDEX_W       = $clog2(FRAME_BYTES);
   localparam int STORE_AW      = $clog2(PAYLOAD_BYTES);

   localparam logic [7:0]  HEADER_0 = 8'hFE;
   localparam logic [7:0]  HEADER_1 = 8'hEE;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   // round(2^32 / 2pi) and round(2^32 / 4pi), unsigned q0.32
   localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;
   localparam logic [28:0] INV_4PI_Q32 = 29'd341782638;

   localparam logic [INDEX_W-1:0] IDX_CRC_LO = INDEX_W'(PAYLOAD_BYTES);
   localparam logic [INDEX_W-1:0] IDX_CRC_HI = INDEX_W'(PAYLOAD_BYTES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_PACK,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic capture;
      logic multiply;
      logic pack;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_byte;
   } status_type;

   // reflected crc-16, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int j = 0; j < 8; j++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // clamp a 19-bit signed value to int16
   function automatic logic [15:0] sat16(input logic [18:0] v);
      logic same;
      same = (v[18:15] == 4'b0000) || (v[18:15] == 4'b1111);
      if (same) begin
         return v[15:0];
      end else if (v[18]) begin
         return 16'h8000;
      end else begin
         return 16'h7FFF;
      end
   endfunction

endpackage
`default_nettype wire

[src/mcfe_ctrl.sv]
// controller state machine of the motor command frame encoder
`default_nettype none
module mcfe_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire mcfe_pkg::status_type status,
   output mcfe_pkg::cmd_type       cmd
);
   import mcfe_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = ST_PACK;
         end
         ST_PACK: begin
            cmd.pack = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               if (status.last_byte) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MUL))
      else $error("accepted command did not start the multiply step");

   a_mul_to_pack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (state_ff == ST_PACK) && req_stall)
      else $error("multiply step not followed by pack");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && status.last_byte) |=> !req_stall)
      else $error("controller did not return to idle after the last byte");

endmodule
`default_nettype wire

[src/mcfe_datapath.sv]
// scaling, frame store, crc and output register of the motor command frame encoder
`default_nettype none
module mcfe_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mcfe_pkg::cmd_type   cmd,
   output mcfe_pkg::status_type     status,
   input  wire logic                csr_we,
   input  wire logic [3:0]          csr_wdata,
   input  wire logic [2:0]          req_mode,
   input  wire logic signed [15:0]  req_torque_q8,
   input  wire logic signed [15:0]  req_speed_q8,
   input  wire logic signed [31:0]  req_position_q16,
   input  wire logic signed [15:0]  req_stiffness_q8,
   input  wire logic signed [15:0]  req_damping_q8,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_frame_byte,
   output logic                     rsp_frame_end
);
   import mcfe_pkg::*;

   logic [3:0]  motor_id_ff;

   // captured command
   logic [2:0]  mode_ff;
   logic [15:0] torque_ff;
   logic [16:0] speed_mag_ff;
   logic        speed_neg_ff;
   logic [31:0] pos_mag_ff;
   logic        pos_neg_ff;
   logic [15:0] kp_ff;
   logic [15:0] kw_ff;

   // upper product bits
   logic [14:0] speed_hi_ff;
   logic [28:0] pos_hi_ff;

   logic [7:0]  frame_store_ff [PAYLOAD_BYTES];
   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [INDEX_W-1:0] index_ff;
   logic [INDEX_W-1:0] index_in;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_end_ff;

   logic [16:0] speed_mag_in;
   logic [31:0] pos_mag_in;
   logic [46:0] speed_prod;
   logic [60:0] pos_prod;
   logic [16:0] w_val;
   logic [15:0] w_sat;
   logic [31:0] pos_val;
   logic [18:0] kp_ext;
   logic [18:0] kw_ext;
   logic [18:0] kp5;
   logic [18:0] kw5;
   logic [15:0] kp_sat;
   logic [15:0] kw_sat;
   logic [7:0]  next_byte;
   logic        in_payload;

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_id_ff <= '0;
      end else if (csr_we) begin
         motor_id_ff <= csr_wdata;
      end
   end

   assign speed_mag_in = req_speed_q8[15] ? (17'd0 - {req_speed_q8[15], req_speed_q8})
                                          : {1'b0, req_speed_q8};
   assign pos_mag_in   = req_position_q16[31] ? (32'd0 - req_position_q16) : req_position_q16;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff      <= req_mode;
         torque_ff    <= req_torque_q8;
         speed_mag_ff <= speed_mag_in;
         speed_neg_ff <= req_speed_q8[15];
         pos_mag_ff   <= pos_mag_in;
         pos_neg_ff   <= req_position_q16[31];
         kp_ff        <= req_stiffness_q8;
         kw_ff        <= req_damping_q8;
      end
   end

   assign speed_prod = 47'(speed_mag_ff) * 47'(INV_2PI_Q32);
   assign pos_prod   = 61'(pos_mag_ff) * 61'(INV_4PI_Q32);

   always_ff @(posedge clock) begin
      if (cmd.multiply) begin
         speed_hi_ff <= speed_prod[46:32];
         pos_hi_ff   <= pos_prod[60:32];
      end
   end

   // sign goes back on after the shift, so results truncate toward zero
   assign w_val   = speed_neg_ff ? (17'd0 - {2'b00, speed_hi_ff}) : {2'b00, speed_hi_ff};
   assign w_sat   = sat16({{2{w_val[16]}}, w_val});
   assign pos_val = pos_neg_ff ? (32'd0 - {3'b000, pos_hi_ff}) : {3'b000, pos_hi_ff};
   assign kp_ext  = {{3{kp_ff[15]}}, kp_ff};
   assign kw_ext  = {{3{kw_ff[15]}}, kw_ff};
   assign kp5     = (kp_ext << 2) + kp_ext;
   assign kw5     = (kw_ext << 2) + kw_ext;
   assign kp_sat  = sat16(kp5);
   assign kw_sat  = sat16(kw5);

   always_ff @(posedge clock) begin
      if (cmd.pack) begin
         frame_store_ff[0]  <= HEADER_0;
         frame_store_ff[1]  <= HEADER_1;
         frame_store_ff[2]  <= {1'b0, mode_ff, motor_id_ff};
         frame_store_ff[3]  <= torque_ff[7:0];
         frame_store_ff[4]  <= torque_ff[15:8];
         frame_store_ff[5]  <= w_sat[7:0];
         frame_store_ff[6]  <= w_sat[15:8];
         frame_store_ff[7]  <= pos_val[7:0];
         frame_store_ff[8]  <= pos_val[15:8];
         frame_store_ff[9]  <= pos_val[23:16];
         frame_store_ff[10] <= pos_val[31:24];
         frame_store_ff[11] <= kp_sat[7:0];
         frame_store_ff[12] <= kp_sat[15:8];
         frame_store_ff[13] <= kw_sat[7:0];
         frame_store_ff[14] <= kw_sat[15:8];
      end
   end

   assign in_payload = (index_ff < IDX_CRC_LO);

   always_comb begin
      priority if (in_payload) begin
         next_byte = frame_store_ff[index_ff[STORE_AW-1:0]];
      end else if (index_ff == IDX_CRC_LO) begin
         next_byte = crc_ff[7:0];
      end else begin
         next_byte = crc_ff[15:8];
      end
   end

   always_comb begin
      crc_in   = crc_ff;
      index_in = index_ff;
      if (cmd.pack) begin
         crc_in   = '0;
         index_in = '0;
      end else if (cmd.load) begin
         if (in_payload) begin
            crc_in = crc_byte(crc_ff, next_byte);
         end
         if (status.last_byte) begin
            index_in = '0;
         end else begin
            index_in = index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= '0;
         index_ff <= '0;
      end else begin
         crc_ff   <= crc_in;
         index_ff <= index_in;
      end
   end

   // output register, refilled as soon as the held beat leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_byte_ff <= next_byte;
         rsp_end_ff  <= status.last_byte;
      end
   end

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.last_byte = (index_ff == IDX_CRC_HI);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_frame_end  = rsp_end_ff;

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= IDX_CRC_HI)
      else $error("byte index past the end of the frame");

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && status.last_byte) |=> (rsp_valid && rsp_frame_end && (index_ff == '0)))
      else $error("last crc byte not flagged as frame end");

   a_pack_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.pack |=> ((crc_ff == '0) && (index_ff == '0)))
      else $error("crc or byte index not cleared at frame start");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !cmd.load)
      else $error("held beat overwritten");

endmodule
`default_nettype wire

[src/motor_command_frame_encoder.sv]
// Motor command frame encoder: one command in, a 17-byte crc-16 frame out.
// The first frame byte is loaded into the output register after the capture, multiply and pack steps.
// Throughput: 17 output beats per command, one per cycle while rsp_stall is low; a new
//   command is taken only after the last beat of the previous frame is loaded (capture,
//   multiply, pack, then 17 loads of the output register; the byte-serial crc sets the pace).
// Reset (synchronous): clears the state machine, crc, byte index, output valid and
//   motor_id; the frame store is not cleared and is rewritten for every command.
`default_nettype none
module motor_command_frame_encoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [3:0]         csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_mode,
   input  wire logic signed [15:0] req_torque_q8,
   input  wire logic signed [15:0] req_speed_q8,
   input  wire logic signed [31:0] req_position_q16,
   input  wire logic signed [15:0] req_stiffness_q8,
   input  wire logic signed [15:0] req_damping_q8,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_frame_byte,
   output logic                    rsp_frame_end
);
   import mcfe_pkg::*;

   cmd_type    cmd;
   status_type status;

   mcfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mcfe_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_mode         (req_mode),
      .req_torque_q8    (req_torque_q8),
      .req_speed_q8     (req_speed_q8),
      .req_position_q16 (req_position_q16),
      .req_stiffness_q8 (req_stiffness_q8),
      .req_damping_q8   (req_damping_q8),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule
`default_nettype wire

[sim/testbench.sv]
// self-checking testbench for the motor command frame encoder
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mcfe_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic [2:0]         mode;
      logic signed [15:0] torque;
      logic signed [15:0] speed;
      logic signed [31:0] position;
      logic signed [15:0] stiffness;
      logic signed [15:0] damping;
   } motor_cmd_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_beat_type;

   class frame_scoreboard;
      frame_beat_type frame_bytes_due[$];
      int             mismatches;

      function new();
         mismatches = 0;
      endfunction

      function longint clamp(longint v, int w);
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (w - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      // multiply by an unsigned q0.32 constant, truncating toward zero
      function longint scale_q32(longint x, longint unsigned k);
         longint unsigned mag;
         longint          r;
         mag = (x < 0) ? longint'(-x) : longint'(x);
         r = longint'((mag * k) >> 32);
         return (x < 0) ? -r : r;
      endfunction

      function int pending();
         return frame_bytes_due.size();
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      // build the whole 17-byte frame that one accepted command must produce
      function void note_command(motor_cmd_type c, logic [3:0] id);
         logic [7:0]  frame [FRAME_BYTES];
         logic [63:0] t, w, pos, kp, kw;
         logic [15:0] crc;
         t   = clamp(longint'(c.torque), 16);
         w   = clamp(scale_q32(longint'(c.speed), INV_2PI_Q32), 16);
         pos = clamp(scale_q32(longint'(c.position), INV_4PI_Q32), 32);
         kp  = clamp(5 * longint'(c.stiffness), 16);
         kw  = clamp(5 * longint'(c.damping), 16);
         frame[0]  = HEADER_0;
         frame[1]  = HEADER_1;
         frame[2]  = {1'b0, c.mode, id};
         frame[3]  = t[7:0];
         frame[4]  = t[15:8];
         frame[5]  = w[7:0];
         frame[6]  = w[15:8];
         frame[7]  = pos[7:0];
         frame[8]  = pos[15:8];
         frame[9]  = pos[23:16];
         frame[10] = pos[31:24];
         frame[11] = kp[7:0];
         frame[12] = kp[15:8];
         frame[13] = kw[7:0];
         frame[14] = kw[15:8];
         crc = 16'h0000;
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            crc = crc ^ {8'h00, frame[i]};
            for (int j = 0; j < 8; j++) begin
               if (crc[0]) begin
                  crc = (crc >> 1) ^ CRC_POLY;
               end else begin
                  crc = crc >> 1;
               end
            end
         end
         frame[15] = crc[7:0];
         frame[16] = crc[15:8];
         for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_bytes_due.push_back('{frame[i], i == FRAME_BYTES - 1});
         end
      endfunction

      function void check_beat(logic [7:0] data, logic last);
         frame_beat_type want;
         if (frame_bytes_due.size() == 0) begin
            report($sformatf("unexpected beat byte %02h end %0b", data, last));
            return;
         end
         want = frame_bytes_due.pop_front();
         if (want.data !== data || want.last !== last) begin
            report($sformatf("expected byte %02h end %0b, got byte %02h end %0b",
                             want.data, want.last, data, last));
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [3:0]         csr_wdata = 4'h0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_mode = 3'd0;
   logic signed [15:0] req_torque_q8 = 16'sd0;
   logic signed [15:0] req_speed_q8 = 16'sd0;
   logic signed [31:0] req_position_q16 = 32'sd0;
   logic signed [15:0] req_stiffness_q8 = 16'sd0;
   logic signed [15:0] req_damping_q8 = 16'sd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_frame_byte;
   logic               rsp_frame_end;

   frame_scoreboard sb = new();
   logic [3:0]      motor_id_now = 4'h0;
   bit              idle_on = 1'b1;
   int              cycle_count = 0;

   motor_command_frame_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_torque_q8    (req_torque_q8),
      .req_speed_q8     (req_speed_q8),
      .req_position_q16 (req_position_q16),
      .req_stiffness_q8 (req_stiffness_q8),
      .req_damping_q8   (req_damping_q8),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int draw_wait();
      return idle_on ? $urandom_range(0, 11) : 0;
   endfunction

   function automatic logic [15:0] random16();
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 511) - 256;
         2: begin
            // around the point where five times the gain leaves int16
            v = $urandom_range(6545, 6565);
            if ($urandom_range(0, 1)) v = -v;
         end
         default: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000;
               1: v = 32'h7FFF;
               2: v = 0;
               default: v = 32'hFFFF;
            endcase
         end
      endcase
      return v[15:0];
   endfunction

   function automatic logic [31:0] random32();
      case ($urandom_range(0, 3))
         0, 1: return $urandom;
         2: return 32'($urandom_range(0, 2000000)) - 32'd1000000;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic motor_cmd_type random_command();
      motor_cmd_type c;
      c.mode      = 3'($urandom_range(0, 7));
      c.torque    = random16();
      c.speed     = random16();
      c.position  = random32();
      c.stiffness = random16();
      c.damping   = random16();
      return c;
   endfunction

   // entered and left at a falling edge
   task automatic send_command(motor_cmd_type c);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode         <= c.mode;
      req_torque_q8    <= c.torque;
      req_speed_q8     <= c.speed;
      req_position_q16 <= c.position;
      req_stiffness_q8 <= c.stiffness;
      req_damping_q8   <= c.damping;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_command(c, motor_id_now);
      @(negedge clock);
   endtask

   task automatic drain_frames();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_motor_id(logic [3:0] id);
      csr_we    <= 1'b1;
      csr_wdata <= id;
      @(negedge clock);
      csr_we <= 1'b0;
      motor_id_now = id;
   endtask

   // result side: a random stall, possibly none, before every beat
   initial begin
      int n;
      forever begin
         @(negedge clock);
         n = draw_wait();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_beat(rsp_frame_byte, rsp_frame_end);
      end
   end

   initial begin
      motor_cmd_type c;
      logic [3:0]    id;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed commands, motor id still at its reset value
      send_command('{3'd0, 16'sh0000, 16'sh0000, 32'sh0000_0000, 16'sh0000, 16'sh0000});
      send_command('{3'd7, 16'sh7FFF, 16'sh7FFF, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF});
      send_command('{3'd1, 16'sh8000, 16'sh8000, 32'sh8000_0000, 16'sh8000, 16'sh8000});
      send_command('{3'd2, 16'shFFFF, 16'shFFFF, 32'shFFFF_FFFF, 16'shFFFF, 16'shFFFF});
      send_command('{3'd3, 16'sh0001, 16'sh0001, 32'sh0000_0001, 16'sh0001, 16'sh0001});
      // gains just inside and just outside the int16 range after scaling
      send_command('{3'd4, 16'sh0100, 16'sh0648, 32'sh000C_90FE, 16'sh1999, 16'shE667});
      send_command('{3'd5, 16'sh1234, 16'shF9B8, 32'shFFF3_6F02, 16'sh199A, 16'shE666});
      drain_frames();
      write_motor_id(4'hF);
      send_command('{3'd6, 16'sh5555, 16'shAAAA, 32'sh5555_5555, 16'shAAAA, 16'sh5555});
      send_command('{3'd7, 16'shAAAA, 16'sh5555, 32'shAAAA_AAAA, 16'sh5555, 16'shAAAA});
      send_command('{3'd0, 16'sh8000, 16'sh7FFF, 32'sh0000_0000, 16'sh199A, 16'sh199A});
      // small values that truncate toward zero from both sides
      send_command('{3'd4, 16'sh0006, 16'shFFFA, 32'shFFFF_FFF4, 16'sh0000, 16'sh0000});
      send_command('{3'd2, 16'sh0007, 16'sh0007, 32'sh0000_000D, 16'shE666, 16'sh199A});
      send_command('{3'd3, 16'shFFF9, 16'shFFF9, 32'shFFFF_FFF3, 16'sh8000, 16'sh7FFF});

      for (int phase = 0; phase < 10; phase++) begin
         drain_frames();
         case (phase)
            0: id = 4'h0;
            5: id = 4'hF;
            default: id = 4'($urandom_range(0, 15));
         endcase
         write_motor_id(id);
         idle_on = (phase % 4) != 3;
         for (int k = 0; k < 50; k++) begin
            c = random_command();
            send_command(c);
         end
      end

      drain_frames();
      idle_on = 1'b0;
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
src/mcfe_pkg.sv
src/mcfe_ctrl.sv
src/mcfe_datapath.sv
src/motor_command_frame_encoder.sv
sim/testbench.sv
